>>> design/ogta_pkg.sv
// ----------------------------------------------------------------------------
// ogta_pkg: shared types and constants for online greedy task assignment
// Holds table entry layouts, the controller command and status bundles and
// the fixed field widths used by the controller and the datapath.
// ----------------------------------------------------------------------------
package ogta_pkg;

  // Default number of entries in each table.
  localparam int DEF_TABLE_DEPTH = 256;
  // Copies per arrival are capped here and at the per-request result limit.
  localparam int MAX_COPIES   = 16;
  localparam int RESULT_LIMIT = 16;
  localparam int COPY_LIMIT   = (MAX_COPIES < RESULT_LIMIT) ? MAX_COPIES : RESULT_LIMIT;

  localparam int COORD_W = 16;
  localparam int TIME_W  = 16;
  localparam int END_W   = 17;
  localparam int FACT_W  = 16;
  localparam int GAIN_W  = 32;
  localparam int UTIL_W  = 48;
  localparam int IDX_W   = 8;
  localparam int CIDX_W  = 4;
  localparam int NCOPY_W = 5;

  // One worker table entry.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] radius;
    logic [TIME_W-1:0]  beg_time;
    logic [END_W-1:0]   end_time;
    logic [FACT_W-1:0]  rate;
  } worker_entry_t;

  // One task table entry.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [TIME_W-1:0]  beg_time;
    logic [END_W-1:0]   end_time;
    logic [FACT_W-1:0]  pay;
  } task_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;       // capture the accepted request
    logic              store;      // write the copy into its table, clear the scan
    logic              scan;       // issue scan reads while entries remain
    logic              commit;     // apply the match and load the result register
    logic [CIDX_W-1:0] copy_index;
    logic              last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;       // own table has no free slot
    logic scan_done;  // all reads issued and the compare pipeline drained
  } dp_sts_t;

endpackage

>>> design/ogta_ctrl.sv
// ----------------------------------------------------------------------------
// ogta_ctrl: sequencing controller
// Accepts requests, walks through the unit copies of each arrival and steps
// every copy through store, scan (not when its table is full), commit and result delivery.
// ----------------------------------------------------------------------------
module ogta_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [ogta_pkg::NCOPY_W-1:0] in_copies,
  output logic                      out_valid,
  input  logic                      out_stall,
  output ogta_pkg::dp_cmd_t         cmd,
  input  ogta_pkg::dp_sts_t         sts
);
  import ogta_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_STORE  = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_COMMIT = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [NCOPY_W-1:0] copy_r, copy_nxt;
  logic [NCOPY_W-1:0] count_r, count_nxt;
  logic [NCOPY_W-1:0] clamped;
  logic               accept;
  logic               is_last;

  // Clamp the requested copy count.
  assign clamped = (in_copies > NCOPY_W'(COPY_LIMIT)) ? NCOPY_W'(COPY_LIMIT) : in_copies;
  assign accept  = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_RESULT);
  assign is_last   = ((copy_r + NCOPY_W'(1)) == count_r);

  // Next state and copy counter.
  always_comb begin
    state_nxt = state_r;
    copy_nxt  = copy_r;
    count_nxt = count_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (clamped != '0)) begin
          state_nxt = ST_STORE;
          copy_nxt  = '0;
          count_nxt = clamped;
        end
      end
      ST_STORE: begin
        state_nxt = sts.full ? ST_COMMIT : ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_stall) begin
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_STORE;
            copy_nxt  = copy_r + NCOPY_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd            = '0;
    cmd.load       = accept;
    cmd.store      = (state_r == ST_STORE);
    cmd.scan       = (state_r == ST_SCAN);
    cmd.commit     = (state_r == ST_COMMIT);
    cmd.copy_index = copy_r[CIDX_W-1:0];
    cmd.last       = is_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      copy_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      copy_r  <= copy_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

>>> design/ogta_datapath.sv
// ----------------------------------------------------------------------------
// ogta_datapath: tables, scan pipeline and result register
// Holds the worker and task tables, scans the opposite table through a
// four-stage compare pipeline and keeps the running utility.
// ----------------------------------------------------------------------------
module ogta_datapath #(
  parameter int TABLE_DEPTH = ogta_pkg::DEF_TABLE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ogta_pkg::dp_cmd_t               cmd,
  output ogta_pkg::dp_sts_t               sts,
  input  logic                            in_is_worker,
  input  logic [ogta_pkg::COORD_W-1:0]    in_loc_x,
  input  logic [ogta_pkg::COORD_W-1:0]    in_loc_y,
  input  logic [ogta_pkg::COORD_W-1:0]    in_radius,
  input  logic [ogta_pkg::TIME_W-1:0]     in_begin_time,
  input  logic [ogta_pkg::TIME_W-1:0]     in_duration,
  input  logic [ogta_pkg::FACT_W-1:0]     in_weight_factor,
  output logic [ogta_pkg::CIDX_W-1:0]     out_copy_index,
  output logic                            out_stored,
  output logic [ogta_pkg::IDX_W-1:0]      out_stored_index,
  output logic                            out_matched,
  output logic [ogta_pkg::IDX_W-1:0]      out_partner_index,
  output logic [ogta_pkg::GAIN_W-1:0]     out_gain,
  output logic [ogta_pkg::UTIL_W-1:0]     out_utility_total,
  output logic                            out_last
);
  import ogta_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // Captured request.
  logic               is_w_r;
  logic [COORD_W-1:0] x_r, y_r, rad_r;
  logic [TIME_W-1:0]  beg_r;
  logic [END_W-1:0]   end_r;
  logic [FACT_W-1:0]  fac_r;

  // Tables.
  worker_entry_t wmem [TABLE_DEPTH];
  task_entry_t   tmem [TABLE_DEPTH];
  logic          wbusy [TABLE_DEPTH];
  logic          tbusy [TABLE_DEPTH];
  logic [CW-1:0] wcnt_r, tcnt_r;

  // Per-copy results.
  logic          stored_r;
  logic [AW-1:0] slot_r;
  logic          matched_r;
  logic [AW-1:0] partner_r;
  logic [GAIN_W-1:0] best_r;
  logic [UTIL_W-1:0] util_r;

  // Scan pipeline.
  logic [CW-1:0] addr_r;
  logic [CW-1:0] opp_cnt;
  logic          issue;
  logic          v1_r, v2_r, v3_r, v4_r;
  logic [AW-1:0] i1_r, i2_r, i3_r;
  worker_entry_t wrd_r;
  task_entry_t   trd_r;
  logic          wbrd_r, tbrd_r;

  logic               full;
  logic [AW-1:0]      own_addr;
  logic [COORD_W-1:0] o_x, o_y, o_rad;
  logic [TIME_W-1:0]  o_beg;
  logic [END_W-1:0]   o_end;
  logic [FACT_W-1:0]  o_fac;
  logic               o_busy;

  logic [COORD_W-1:0] dx2_r, dy2_r, rad2_r;
  logic [FACT_W-1:0]  fac2_r;
  logic               ok2_r;
  logic [2*COORD_W-1:0] dxsq3_r, dysq3_r, rsq3_r;
  logic [GAIN_W-1:0]  w3_r;
  logic               ok3_r;
  logic [2*COORD_W:0] dist_sum;

  logic [UTIL_W:0]    util_sum;
  logic [UTIL_W-1:0]  util_upd;
  logic               wb_we, tb_we;
  logic [AW-1:0]      wb_addr, tb_addr;

  assign full     = is_w_r ? (wcnt_r == CW'(TABLE_DEPTH)) : (tcnt_r == CW'(TABLE_DEPTH));
  assign own_addr = is_w_r ? wcnt_r[AW-1:0] : tcnt_r[AW-1:0];
  assign opp_cnt  = is_w_r ? tcnt_r : wcnt_r;
  assign issue    = cmd.scan && (addr_r != opp_cnt);

  assign sts.full      = full;
  assign sts.scan_done = (addr_r == opp_cnt) && !v1_r && !v2_r && !v3_r && !v4_r;

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_w_r <= in_is_worker;
      x_r    <= in_loc_x;
      y_r    <= in_loc_y;
      rad_r  <= in_radius;
      beg_r  <= in_begin_time;
      end_r  <= END_W'(in_begin_time) + END_W'(in_duration);
      fac_r  <= in_weight_factor;
    end
  end

  // Table entry writes and registered scan reads.
  always_ff @(posedge clk) begin
    if (cmd.store && !full && is_w_r) begin
      wmem[own_addr] <= '{x: x_r, y: y_r, radius: rad_r, beg_time: beg_r,
                          end_time: end_r, rate: fac_r};
    end
    wrd_r <= wmem[addr_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.store && !full && !is_w_r) begin
      tmem[own_addr] <= '{x: x_r, y: y_r, beg_time: beg_r, end_time: end_r, pay: fac_r};
    end
    trd_r <= tmem[addr_r[AW-1:0]];
  end

  // Busy flags: cleared on store, set for both sides on a match.
  always_comb begin
    wb_we   = (cmd.store && !full && is_w_r) || (cmd.commit && matched_r);
    tb_we   = (cmd.store && !full && !is_w_r) || (cmd.commit && matched_r);
    wb_addr = is_w_r ? (cmd.store ? own_addr : slot_r) : partner_r;
    tb_addr = is_w_r ? partner_r : (cmd.store ? own_addr : slot_r);
  end

  always_ff @(posedge clk) begin
    if (wb_we) begin
      wbusy[wb_addr] <= cmd.commit;
    end
    wbrd_r <= wbusy[addr_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (tb_we) begin
      tbusy[tb_addr] <= cmd.commit;
    end
    tbrd_r <= tbusy[addr_r[AW-1:0]];
  end

  // Counters, scan address and pipeline valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcnt_r <= '0;
      tcnt_r <= '0;
      addr_r <= '0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      util_r <= '0;
    end else begin
      if (cmd.store && !full) begin
        if (is_w_r) begin
          wcnt_r <= wcnt_r + CW'(1);
        end else begin
          tcnt_r <= tcnt_r + CW'(1);
        end
      end
      if (cmd.store) begin
        addr_r <= '0;
      end else if (issue) begin
        addr_r <= addr_r + CW'(1);
      end
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      if (cmd.commit) begin
        util_r <= util_upd;
      end
    end
  end

  // Pick the opposite entry's fields.
  always_comb begin
    o_x    = is_w_r ? trd_r.x : wrd_r.x;
    o_y    = is_w_r ? trd_r.y : wrd_r.y;
    o_beg  = is_w_r ? trd_r.beg_time : wrd_r.beg_time;
    o_end  = is_w_r ? trd_r.end_time : wrd_r.end_time;
    o_fac  = is_w_r ? trd_r.pay : wrd_r.rate;
    o_rad  = is_w_r ? rad_r : wrd_r.radius;
    o_busy = is_w_r ? tbrd_r : wbrd_r;
  end

  // Stage two: distances and the window test.
  always_ff @(posedge clk) begin
    i1_r   <= addr_r[AW-1:0];
    i2_r   <= i1_r;
    dx2_r  <= (x_r > o_x) ? (x_r - o_x) : (o_x - x_r);
    dy2_r  <= (y_r > o_y) ? (y_r - o_y) : (o_y - y_r);
    rad2_r <= o_rad;
    fac2_r <= o_fac;
    ok2_r  <= !o_busy && (END_W'(beg_r) < o_end) && (END_W'(o_beg) < end_r);
  end

  // Stage three: squares and weight.
  always_ff @(posedge clk) begin
    i3_r    <= i2_r;
    dxsq3_r <= dx2_r * dx2_r;
    dysq3_r <= dy2_r * dy2_r;
    rsq3_r  <= rad2_r * rad2_r;
    w3_r    <= GAIN_W'(fac2_r) * GAIN_W'(fac_r);
    ok3_r   <= ok2_r;
  end

  assign dist_sum = (2*COORD_W+1)'(dxsq3_r) + (2*COORD_W+1)'(dysq3_r);

  // Stage four: keep the first entry with the largest weight.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      matched_r <= 1'b0;
      best_r    <= '0;
      partner_r <= '0;
      stored_r  <= !full;
      slot_r    <= full ? '0 : own_addr;
    end else if (v3_r && ok3_r && (dist_sum <= (2*COORD_W+1)'(rsq3_r)) &&
                 (w3_r > best_r)) begin
      matched_r <= 1'b1;
      best_r    <= w3_r;
      partner_r <= i3_r;
    end
  end

  // Saturating utility update.
  assign util_sum = (UTIL_W+1)'(util_r) + (UTIL_W+1)'(best_r);
  always_comb begin
    if (!matched_r) begin
      util_upd = util_r;
    end else if (util_sum[UTIL_W]) begin
      util_upd = '1;
    end else begin
      util_upd = util_sum[UTIL_W-1:0];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_copy_index    <= cmd.copy_index;
      out_stored        <= stored_r;
      out_stored_index  <= IDX_W'(slot_r);
      out_matched       <= matched_r;
      out_partner_index <= IDX_W'(partner_r);
      out_gain          <= best_r;
      out_utility_total <= util_upd;
      out_last          <= cmd.last;
    end
  end

endmodule

>>> design/online_greedy_task_assignment.sv
// Scan: each copy reads the N filled entries of the opposite table (one read per
// cycle, a registered read, three compare stages and a drain); a copy whose own
// table is full skips the scan and goes straight to commit.
// The copies of a request are handled one after another, each held as a result
// while out_stall is high; one request is in flight at a time.
// Reset clears both fill counts, the running utility and the controller; table
// contents are undefined until written.
// ----------------------------------------------------------------------------
// online_greedy_task_assignment: top level
// Greedy online matching of arriving workers and tasks over two tables.
// ----------------------------------------------------------------------------
module online_greedy_task_assignment #(
  parameter int TABLE_DEPTH = ogta_pkg::DEF_TABLE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_is_worker,
  input  logic [ogta_pkg::COORD_W-1:0]  in_loc_x,
  input  logic [ogta_pkg::COORD_W-1:0]  in_loc_y,
  input  logic [ogta_pkg::COORD_W-1:0]  in_radius,
  input  logic [ogta_pkg::TIME_W-1:0]   in_begin_time,
  input  logic [ogta_pkg::TIME_W-1:0]   in_duration,
  input  logic [ogta_pkg::FACT_W-1:0]   in_weight_factor,
  input  logic [ogta_pkg::NCOPY_W-1:0]  in_copies,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ogta_pkg::CIDX_W-1:0]   out_copy_index,
  output logic                          out_stored,
  output logic [ogta_pkg::IDX_W-1:0]    out_stored_index,
  output logic                          out_matched,
  output logic [ogta_pkg::IDX_W-1:0]    out_partner_index,
  output logic [ogta_pkg::GAIN_W-1:0]   out_gain,
  output logic [ogta_pkg::UTIL_W-1:0]   out_utility_total,
  output logic                          out_last
);
  import ogta_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencing.
  ogta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_copies (in_copies),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Tables and scan.
  ogta_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_is_worker      (in_is_worker),
    .in_loc_x          (in_loc_x),
    .in_loc_y          (in_loc_y),
    .in_radius         (in_radius),
    .in_begin_time     (in_begin_time),
    .in_duration       (in_duration),
    .in_weight_factor  (in_weight_factor),
    .out_copy_index    (out_copy_index),
    .out_stored        (out_stored),
    .out_stored_index  (out_stored_index),
    .out_matched       (out_matched),
    .out_partner_index (out_partner_index),
    .out_gain          (out_gain),
    .out_utility_total (out_utility_total),
    .out_last          (out_last)
  );

endmodule

>>> bench/online_greedy_task_assignment_tb.sv
// ----------------------------------------------------------------------------
// online_greedy_task_assignment_tb: self-checking bench for the greedy matcher
// Drives worker and task requests through a directed table and then random
// traffic, predicts every per-copy result with a bench-side matcher, and
// compares each result field by field under random idling on both sides.
// ----------------------------------------------------------------------------
module online_greedy_task_assignment_tb;
  import ogta_pkg::*;

  localparam int DEPTH = 256;

  // One arrival as driven on the input ports.
  typedef struct packed {
    logic               is_worker;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] radius;
    logic [TIME_W-1:0]  begin_t;
    logic [TIME_W-1:0]  dur;
    logic [FACT_W-1:0]  factor;
    logic [NCOPY_W-1:0] copies;
  } arrival_t;

  // One per-copy result.
  typedef struct packed {
    logic [CIDX_W-1:0] copy_index;
    logic              stored;
    logic [IDX_W-1:0]  stored_index;
    logic              matched;
    logic [IDX_W-1:0]  partner_index;
    logic [GAIN_W-1:0] gain;
    logic [UTIL_W-1:0] utility_total;
    logic              last;
  } match_result_t;

  // A directed row: an arrival plus, optionally, the first result typed in.
  typedef struct packed {
    arrival_t      arr;
    logic          typed;
    match_result_t first;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  arrival_t drv = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  match_result_t mon;

  // Bench copy of both tables and the running utility.
  logic [COORD_W-1:0] wk_x [DEPTH], wk_y [DEPTH], wk_r [DEPTH], tk_x [DEPTH], tk_y [DEPTH];
  logic [TIME_W-1:0]  wk_b [DEPTH], tk_b [DEPTH];
  logic [END_W-1:0]   wk_e [DEPTH], tk_e [DEPTH];
  logic [FACT_W-1:0]  wk_rate [DEPTH], tk_pay [DEPTH];
  logic               wk_busy [DEPTH], tk_busy [DEPTH];
  int unsigned        wk_fill = 0, tk_fill = 0;
  logic [UTIL_W-1:0]  utility = '0;

  match_result_t pending_results[$];
  stim_row_t     dir_rows[$];
  int errors = 0, n_requests = 0, n_results = 0, n_matches = 0, n_unstored = 0;
  int quiet = 0;
  int stall_left = 0;

  online_greedy_task_assignment i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_is_worker(drv.is_worker), .in_loc_x(drv.x), .in_loc_y(drv.y),
    .in_radius(drv.radius), .in_begin_time(drv.begin_t), .in_duration(drv.dur),
    .in_weight_factor(drv.factor), .in_copies(drv.copies),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_copy_index(mon.copy_index), .out_stored(mon.stored),
    .out_stored_index(mon.stored_index), .out_matched(mon.matched),
    .out_partner_index(mon.partner_index), .out_gain(mon.gain),
    .out_utility_total(mon.utility_total), .out_last(mon.last)
  );

  // Clock with a period of 4.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Time windows must overlap strictly and the task must lie within the radius.
  function automatic logic reachable(logic [15:0] wx, logic [15:0] wy, logic [15:0] wr,
                                     logic [15:0] wb, logic [16:0] we, logic [15:0] tx,
                                     logic [15:0] ty, logic [15:0] tb, logic [16:0] te);
    logic [63:0] dx, dy;
    if (!({1'b0, wb} < te && {1'b0, tb} < we)) return 1'b0;
    dx = (wx > tx) ? 64'(wx - tx) : 64'(tx - wx);
    dy = (wy > ty) ? 64'(wy - ty) : 64'(ty - wy);
    return (dx * dx + dy * dy) <= 64'(wr) * 64'(wr);
  endfunction

  // Store each copy, scan the opposite table, and queue the expected results.
  task automatic predict_matches(arrival_t a, output int n);
    match_result_t res;
    logic [16:0] e;
    logic [31:0] w, best;
    int slot, partner, i;
    logic ok;
    e = 17'(a.begin_t) + 17'(a.dur);
    n = (a.copies > COPY_LIMIT) ? COPY_LIMIT : int'(a.copies);
    for (int k = 0; k < n; k++) begin
      best = '0; slot = 0; partner = 0; ok = 1'b0;
      res = '0;
      if (a.is_worker && wk_fill < DEPTH) begin
        slot = wk_fill; wk_fill++; res.stored = 1'b1;
        wk_x[slot] = a.x; wk_y[slot] = a.y; wk_r[slot] = a.radius; wk_b[slot] = a.begin_t;
        wk_e[slot] = e; wk_rate[slot] = a.factor; wk_busy[slot] = 1'b0;
        for (i = 0; i < tk_fill; i++) begin
          w = 32'(tk_pay[i]) * 32'(a.factor);
          if (tk_busy[i] || w <= best) continue;
          if (!reachable(a.x, a.y, a.radius, a.begin_t, e, tk_x[i], tk_y[i], tk_b[i],
                         tk_e[i])) continue;
          best = w; partner = i; ok = 1'b1;
        end
        if (ok) begin
          wk_busy[slot] = 1'b1; tk_busy[partner] = 1'b1;
        end
      end else if (!a.is_worker && tk_fill < DEPTH) begin
        slot = tk_fill; tk_fill++; res.stored = 1'b1;
        tk_x[slot] = a.x; tk_y[slot] = a.y; tk_b[slot] = a.begin_t; tk_e[slot] = e;
        tk_pay[slot] = a.factor; tk_busy[slot] = 1'b0;
        for (i = 0; i < wk_fill; i++) begin
          w = 32'(wk_rate[i]) * 32'(a.factor);
          if (wk_busy[i] || w <= best) continue;
          if (!reachable(wk_x[i], wk_y[i], wk_r[i], wk_b[i], wk_e[i], a.x, a.y, a.begin_t,
                         e)) continue;
          best = w; partner = i; ok = 1'b1;
        end
        if (ok) begin
          tk_busy[slot] = 1'b1; wk_busy[partner] = 1'b1;
        end
      end
      // Saturating utility.
      if (ok) begin
        if (utility > {UTIL_W{1'b1}} - 48'(best)) utility = {UTIL_W{1'b1}};
        else utility = utility + 48'(best);
        n_matches++;
      end else begin
        best = '0; partner = 0;
      end
      if (!res.stored) n_unstored++;
      res.copy_index = CIDX_W'(k);
      res.stored_index = IDX_W'(slot);
      res.matched = ok;
      res.partner_index = IDX_W'(partner);
      res.gain = best;
      res.utility_total = utility;
      res.last = (k + 1 == n);
      pending_results.insert(pending_results.size(), res);
    end
  endtask

  // Wait a random gap, then hold the request until it is accepted. Valid is
  // left high after acceptance; the next call drops it or drives its own request at once, or the caller drops it.
  task automatic send_request(arrival_t a, logic typed, match_result_t first);
    int gap, n, idx;
    gap = quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    drv <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    idx = pending_results.size();
    predict_matches(a, n);
    if (typed && n > 0) pending_results[idx] = first;
    n_requests++;
  endtask

  // Mostly clustered arrivals so that matches happen; the rest span every bit.
  function automatic arrival_t random_arrival();
    arrival_t a;
    logic [127:0] raw;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 8) begin
      a.is_worker = 1'($urandom_range(0, 1));
      a.x = COORD_W'($urandom_range(0, 2000));
      a.y = COORD_W'($urandom_range(0, 2000));
      a.radius = COORD_W'($urandom_range(0, 3000));
      a.begin_t = TIME_W'($urandom_range(0, 1000));
      a.dur = TIME_W'($urandom_range(0, 2000));
      a.factor = (sel == 0) ? FACT_W'(0) : FACT_W'($urandom);
    end else begin
      raw = {$urandom, $urandom, $urandom, $urandom};
      a = raw[$bits(arrival_t)-1:0];
    end
    sel = $urandom_range(0, 19);
    if (sel < 17) a.copies = NCOPY_W'($urandom_range(1, 2));
    else if (sel < 19) a.copies = NCOPY_W'($urandom_range(3, 31));
    else a.copies = '0;
    return a;
  endfunction

  function automatic stim_row_t row(logic w, int x, int y, int r, int b, int d, int f,
                                    int c);
    stim_row_t s;
    s = '0;
    s.arr = '{w, COORD_W'(x), COORD_W'(y), COORD_W'(r), TIME_W'(b), TIME_W'(d),
              FACT_W'(f), NCOPY_W'(c)};
    return s;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(stim_row_t s);
    dir_rows.insert(dir_rows.size(), s);
  endfunction

  // Result side: random stall lengths, checked against the oldest expectation.
  always @(posedge clk) begin
    match_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (mon.copy_index !== exp_r.copy_index) begin
          $error("copy_index exp %0d got %0d", exp_r.copy_index, mon.copy_index); errors++;
        end
        if (mon.stored !== exp_r.stored) begin
          $error("stored exp %0d got %0d", exp_r.stored, mon.stored); errors++;
        end
        if (mon.stored_index !== exp_r.stored_index) begin
          $error("stored_index exp %0d got %0d", exp_r.stored_index, mon.stored_index);
          errors++;
        end
        if (mon.matched !== exp_r.matched) begin
          $error("matched exp %0d got %0d", exp_r.matched, mon.matched); errors++;
        end
        if (mon.partner_index !== exp_r.partner_index) begin
          $error("partner_index exp %0d got %0d", exp_r.partner_index, mon.partner_index);
          errors++;
        end
        if (mon.gain !== exp_r.gain) begin
          $error("gain exp %0h got %0h", exp_r.gain, mon.gain); errors++;
        end
        if (mon.utility_total !== exp_r.utility_total) begin
          $error("utility_total exp %0h got %0h", exp_r.utility_total, mon.utility_total);
          errors++;
        end
        if (mon.last !== exp_r.last) begin
          $error("last exp %0d got %0d", exp_r.last, mon.last); errors++;
        end
      end
      stall_left = quiet ? 0 : $urandom_range(0, 18);
      out_stall <= (stall_left != 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= (stall_left != 0);
    end
  end

  // Main sequence: reset, directed table, random traffic, drain.
  initial begin
    stim_row_t r;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // First task into an empty table: stored at slot 0 with nothing to match.
    r = row(1'b0, 0, 0, 0, 0, 100, 16'hFFFF, 1);
    r.typed = 1'b1;
    r.first = '{4'd0, 1'b1, 8'd0, 1'b0, 8'd0, 32'd0, 48'd0, 1'b1};
    add_row(r);
    // Co-located worker with full rate takes it at the largest gain.
    r = row(1'b1, 0, 0, 0, 0, 100, 16'hFFFF, 1);
    r.typed = 1'b1;
    r.first = '{4'd0, 1'b1, 8'd0, 1'b1, 8'd0, 32'hFFFE0001, 48'hFFFE0001, 1'b1};
    add_row(r);
    add_row(row(1'b0, 5, 5, 0, 0, 10, 100, 0));        // zero copies
    add_row(row(1'b0, 10, 10, 0, 0, 500, 0, 1));       // zero pay
    add_row(row(1'b1, 10, 10, 100, 0, 500, 300, 1));
    add_row(row(1'b0, 100, 0, 0, 100, 0, 50, 1));      // empty window
    add_row(row(1'b1, 100, 0, 10, 50, 50, 50, 1));     // windows only touch
    add_row(row(1'b0, 30, 40, 0, 0, 1000, 77, 1));
    add_row(row(1'b1, 0, 0, 49, 0, 1000, 88, 1));      // just out of reach
    add_row(row(1'b1, 0, 0, 50, 0, 1000, 88, 1));      // exactly at radius
    add_row(row(1'b0, 200, 200, 0, 0, 1000, 10, 3));
    add_row(row(1'b1, 200, 200, 5, 0, 1000, 20, 2));
    add_row(row(1'b1, 200, 200, 5, 0, 1000, 30, 2));   // higher rate, takes the last free task
    add_row(row(1'b0, 200, 200, 0, 0, 1000, 10, 1));
    add_row(row(1'b1, 65535, 65535, 65535, 65535, 65535, 65535, 31));
    add_row(row(1'b0, 65535, 65535, 65535, 65535, 65535, 65535, 17));
    add_row(row(1'b0, 0, 0, 0, 0, 65535, 65535, 16));
    add_row(row(1'b1, 0, 0, 65535, 0, 65535, 65535, 16));
    foreach (dir_rows[i]) send_request(dir_rows[i].arr, dir_rows[i].typed,
                                       dir_rows[i].first);

    // Random traffic; the sender holds off once until every result is back.
    for (int i = 0; i < 270; i++) begin
      if (i % 40 == 0) quiet = int'($urandom_range(0, 3) == 0);
      if (i == 120) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      send_request(random_arrival(), 1'b0, '0);
    end
    quiet = 0;
    in_valid <= 1'b0;
    @(posedge clk);

    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d requests, checked %0d copy results.", n_requests, n_results);
    $display("Matches: %0d, copies turned away by a full table: %0d.", n_matches,
             n_unstored);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("online_greedy_task_assignment_tb OK");
    end else begin
      $display("online_greedy_task_assignment_tb NOT OK");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20000000;
    $display("online_greedy_task_assignment_tb NOT OK");
    $finish;
  end

endmodule
